// ===== design/brtc_pkg.sv =====
// Shared types, constants and calendar tables for the BCD clock reading unit.
// No dependencies; imported by every module of the unit.
package brtc_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegOffsetDays    = 8'd0;
  localparam logic [CfgIdxW-1:0] RegOffsetHours   = 8'd1;
  localparam logic [CfgIdxW-1:0] RegOffsetMinutes = 8'd2;
  localparam logic [CfgIdxW-1:0] RegOffsetSeconds = 8'd3;

  // Offset limits, writes above are clamped
  localparam logic [4:0] MaxHour   = 5'd23;
  localparam logic [5:0] MaxMinute = 6'd59;

  // Error flag bit positions
  localparam int unsigned FlagPower  = 0;
  localparam int unsigned Flag12Hour = 1;
  localparam int unsigned FlagYear   = 2;
  localparam int unsigned FlagMonth  = 3;
  localparam int unsigned FlagDay    = 4;
  localparam int unsigned FlagHour   = 5;
  localparam int unsigned FlagMinute = 6;
  localparam int unsigned FlagSecond = 7;

  // One raw reading
  typedef struct packed {
    logic       status_power_lost;
    logic       status_24hour;
    logic [7:0] year_bcd;
    logic [7:0] month_bcd;
    logic [7:0] day_bcd;
    logic [7:0] hour_bcd;
    logic [7:0] minute_bcd;
    logic [7:0] second_bcd;
  } rtc_in_t;

  // One result beat
  typedef struct packed {
    logic [7:0]         error_flags;
    logic [15:0]        day_count;
    logic signed [15:0] local_days;
    logic [4:0]         local_hours;
    logic [5:0]         local_minutes;
    logic [5:0]         local_seconds;
  } rtc_out_t;

  // Stored local time offset
  typedef struct packed {
    logic [15:0] days;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } rtc_offset_t;

  // Days in a common year's month; 31 for anything outside 1..12
  function automatic logic [4:0] month_len(input logic [6:0] month);
    logic [4:0] len;
    case (month)
      7'd2:    len = 5'd28;
      7'd4:    len = 5'd30;
      7'd6:    len = 5'd30;
      7'd9:    len = 5'd30;
      7'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Days of a common year that lie before the first of the month
  function automatic logic [8:0] days_before(input logic [6:0] month);
    logic [8:0] d;
    case (month)
      7'd2:    d = 9'd31;
      7'd3:    d = 9'd59;
      7'd4:    d = 9'd90;
      7'd5:    d = 9'd120;
      7'd6:    d = 9'd151;
      7'd7:    d = 9'd181;
      7'd8:    d = 9'd212;
      7'd9:    d = 9'd243;
      7'd10:   d = 9'd273;
      7'd11:   d = 9'd304;
      7'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== design/brtc_calc.sv =====
// Combinational datapath: BCD decode, range checks, day count and local time.
// Depends on brtc_pkg for the beat types and calendar tables.
module brtc_calc
  import brtc_pkg::*;
(
  input  rtc_in_t     item_i,
  input  rtc_offset_t offset_i,
  output rtc_out_t    result_o
);

  logic       year_ok, month_ok, day_ok, hour_ok, minute_ok, second_ok;
  logic [6:0] year_dec, month_bin, day_dec, hour_dec, minute_dec, second_dec;
  logic [7:0] flags;
  logic       leap;
  logic [5:0] day_limit;
  logic [6:0] year_s, month_s, day_s;
  logic [4:0] hour_s;
  logic [5:0] minute_s, second_s;
  logic       leap_s;
  logic [15:0] count;
  logic [6:0] sec_diff, min_diff;
  logic [5:0] hour_diff;
  logic       sec_borrow, min_borrow, hour_borrow;
  logic [6:0] sec_fix, min_fix;
  logic [5:0] hour_fix;

  // Decode one BCD byte: high digit times ten plus low digit
  function automatic logic [6:0] bcd_val(input logic [7:0] b);
    return ({3'd0, b[7:4]} << 3) + ({3'd0, b[7:4]} << 1) + {3'd0, b[3:0]};
  endfunction

  function automatic logic bcd_ok(input logic [7:0] b);
    return (b <= 8'h9F) && (b[3:0] <= 4'd9);
  endfunction

  assign year_ok    = bcd_ok(item_i.year_bcd);
  assign month_ok   = bcd_ok(item_i.month_bcd);
  assign day_ok     = bcd_ok(item_i.day_bcd);
  assign hour_ok    = bcd_ok(item_i.hour_bcd);
  assign minute_ok  = bcd_ok(item_i.minute_bcd);
  assign second_ok  = bcd_ok(item_i.second_bcd);
  assign year_dec   = bcd_val(item_i.year_bcd);
  assign month_bin  = bcd_val(item_i.month_bcd);
  assign day_dec    = bcd_val(item_i.day_bcd);
  assign hour_dec   = bcd_val(item_i.hour_bcd);
  assign minute_dec = bcd_val(item_i.minute_bcd);
  assign second_dec = bcd_val(item_i.second_bcd);

  assign leap = year_ok && (year_dec[1:0] == 2'd0);

  // Check each field; a bad month checks the day against 31 only
  always_comb begin
    flags = '0;
    flags[FlagPower]  = item_i.status_power_lost;
    flags[Flag12Hour] = !item_i.status_24hour;
    flags[FlagYear]   = !year_ok;
    flags[FlagMonth]  = !month_ok || (month_bin == 7'd0) || (month_bin > 7'd12);
    if (flags[FlagMonth]) begin
      day_limit = 6'd31;
    end else begin
      day_limit = {1'b0, month_len(month_bin)} +
                  {5'd0, (month_bin == 7'd2) && leap};
    end
    flags[FlagDay]    = !day_ok || (day_dec == 7'd0) || (day_dec > {1'b0, day_limit});
    flags[FlagHour]   = !hour_ok || (hour_dec > 7'd23);
    flags[FlagMinute] = !minute_ok || (minute_dec > 7'd59);
    flags[FlagSecond] = !second_ok || (second_dec > 7'd59);
  end

  // Replace any flagged reading with 2000-01-01 00:00:00
  always_comb begin
    if (flags != 8'd0) begin
      year_s   = 7'd0;
      month_s  = 7'd1;
      day_s    = 7'd1;
      hour_s   = 5'd0;
      minute_s = 6'd0;
      second_s = 6'd0;
      leap_s   = 1'b1;
    end else begin
      year_s   = year_dec;
      month_s  = month_bin;
      day_s    = day_dec;
      hour_s   = hour_dec[4:0];
      minute_s = minute_dec[5:0];
      second_s = second_dec[5:0];
      leap_s   = leap;
    end
  end

  // Day count: 365 per year, one per leap year before this one, then month and day
  assign count = 16'(year_s) * 16'd365
               + 16'((8'(year_s) + 8'd3) >> 2)
               + 16'(days_before(month_s))
               + 16'((month_s > 7'd2) && leap_s)
               + 16'(day_s);

  // Subtract the offset with borrow from seconds up through hours into days
  always_comb begin
    sec_diff    = {1'b0, second_s} - {1'b0, offset_i.seconds};
    sec_borrow  = sec_diff[6];
    sec_fix     = sec_borrow ? sec_diff + 7'd60 : sec_diff;
    min_diff    = {1'b0, minute_s} - {1'b0, offset_i.minutes} - {6'd0, sec_borrow};
    min_borrow  = min_diff[6];
    min_fix     = min_borrow ? min_diff + 7'd60 : min_diff;
    hour_diff   = {1'b0, hour_s} - {1'b0, offset_i.hours} - {5'd0, min_borrow};
    hour_borrow = hour_diff[5];
    hour_fix    = hour_borrow ? hour_diff + 6'd24 : hour_diff;
  end

  assign result_o.error_flags   = flags;
  assign result_o.day_count     = count;
  assign result_o.local_days    = count - offset_i.days - {15'd0, hour_borrow};
  assign result_o.local_hours   = hour_fix[4:0];
  assign result_o.local_minutes = min_fix[5:0];
  assign result_o.local_seconds = sec_fix[5:0];

endmodule

// ===== design/bcd_rtc_reading_validate_and_day_count_unit.sv =====
// Top level of the BCD clock reading unit: offset registers, input and result stages.
// Depends on brtc_pkg and brtc_calc.
//
// Takes one raw clock reading per cycle and returns its error flags, day count
// since 2000 and local time: the reading is captured in the input register, then
// the single-pass check and count logic feeds the result register, which drives
// the outputs. busy_o never rises, so a new reading may be started in
// every cycle; done_o marks each result for one cycle only and the receiver
// cannot stall it, so it must take every beat as it comes. Offset writes clamp
// hours to 23 and minutes and seconds to 59; unknown indexes are ignored.
// Write the offset only while no reading is in flight.
module bcd_rtc_reading_validate_and_day_count_unit
  import brtc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  rtc_in_t             item_i,
  output logic                done_o,
  output rtc_out_t            result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  rtc_offset_t offset_q, offset_d;
  logic        in_valid_q;
  rtc_in_t     in_q;
  logic        done_q;
  rtc_out_t    result_q;
  rtc_out_t    calc_result;

  // Never hold off a reading
  assign busy_o = 1'b0;

  // Clamp and route configuration writes
  always_comb begin
    offset_d = offset_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegOffsetDays: begin
          offset_d.days = cfg_wdata_i;
        end
        RegOffsetHours: begin
          offset_d.hours = (cfg_wdata_i[4:0] > MaxHour) ? MaxHour : cfg_wdata_i[4:0];
        end
        RegOffsetMinutes: begin
          offset_d.minutes = (cfg_wdata_i[5:0] > MaxMinute) ? MaxMinute : cfg_wdata_i[5:0];
        end
        RegOffsetSeconds: begin
          offset_d.seconds = (cfg_wdata_i[5:0] > MaxMinute) ? MaxMinute : cfg_wdata_i[5:0];
        end
        default: begin
          offset_d = offset_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else begin
      offset_q <= offset_d;
    end
  end

  // Capture the start beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= item_i;
    end
  end

  brtc_calc u_calc (
    .item_i   (in_q),
    .offset_i (offset_q),
    .result_o (calc_result)
  );

  // Register the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      result_q <= calc_result;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== design/brtc_checker.sv =====
// Port-level checks for the BCD clock reading unit, attached by bind.
// Depends on brtc_pkg for the beat types.
module brtc_checker
  import brtc_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input logic     done_o,
  input rtc_out_t result_o
);

  // Every start beat yields a result after the input and result registers
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> ##1 done_o)
    else $error("start beat without result");

  // No result without a matching start beat before it
  a_done_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without start beat");

  // A flagged reading counts as the first day
  a_flag_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.error_flags != 8'd0) |-> result_o.day_count == 16'd1)
    else $error("flagged reading not replaced");

  // Local time fields stay in range and the day count is never zero
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.local_hours <= 5'd23) && (result_o.local_minutes <= 6'd59) &&
               (result_o.local_seconds <= 6'd59) && (result_o.day_count != 16'd0))
    else $error("result field out of range");

endmodule

bind bcd_rtc_reading_validate_and_day_count_unit brtc_checker u_brtc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);

// ===== dv/bcd_rtc_reading_validate_and_day_count_unit_tb.sv =====
// Self-checking testbench for the BCD clock reading unit: validation flags, day count, local time.
// Depends on brtc_pkg and the unit's RTL; a scoreboard class predicts every result beat.
// Offset registers are reprogrammed between phases while the unit is drained.
module bcd_rtc_reading_validate_and_day_count_unit_tb
  import brtc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NumPhases     = 9;
  localparam int          ItemsPerPhase = 90;
  localparam int          SettleCycles  = 4;
  localparam logic [7:0]  BadBcd        = 8'hFF;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  rtc_in_t             item_i;
  logic                done_o;
  rtc_out_t            result_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  always #4 clk_i = ~clk_i;

  bcd_rtc_reading_validate_and_day_count_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Two BCD digits to binary; malformed bytes map to the invalid marker
  function automatic int bcd_value(input logic [7:0] b);
    if (b > 8'h9F || b[3:0] > 4'd9) return int'(BadBcd);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  function automatic logic [7:0] to_bcd(input int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // Length of a month; anything outside 1..12 counts as 31
  function automatic int month_days(input int m, input bit leap);
    case (m)
      2:             return leap ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  class rtc_reading_scoreboard;
    rtc_offset_t ofs;
    rtc_out_t    pending_results[$];
    int          errors;
    int          readings;
    int          flagged;
    int          reg_writes;

    function new();
      ofs = '0;
    endfunction

    // Apply a register write, clamping out-of-range time parts
    function void write_offset_reg(input logic [CfgIdxW-1:0] idx,
                                   input logic [CfgDataW-1:0] data);
      reg_writes++;
      case (idx)
        RegOffsetDays:    ofs.days    = data;
        RegOffsetHours:   ofs.hours   = (data[4:0] > MaxHour)   ? MaxHour   : data[4:0];
        RegOffsetMinutes: ofs.minutes = (data[5:0] > MaxMinute) ? MaxMinute : data[5:0];
        RegOffsetSeconds: ofs.seconds = (data[5:0] > MaxMinute) ? MaxMinute : data[5:0];
        default: ;
      endcase
    endfunction

    // Validate one reading and derive its day count and local time
    function rtc_out_t evaluate_reading(input rtc_in_t r);
      rtc_out_t   res;
      logic [7:0] fl;
      int         y, mo, d, h, mi, s;
      int         lim, cnt, sl, ml, hl;
      bit         leap, borrow;
      y  = bcd_value(r.year_bcd);
      mo = bcd_value(r.month_bcd);
      d  = bcd_value(r.day_bcd);
      h  = bcd_value(r.hour_bcd);
      mi = bcd_value(r.minute_bcd);
      s  = bcd_value(r.second_bcd);
      fl = '0;
      fl[FlagPower]  = r.status_power_lost;
      fl[Flag12Hour] = !r.status_24hour;
      fl[FlagYear]   = (y == int'(BadBcd));
      fl[FlagMonth]  = (mo == int'(BadBcd)) || (mo == 0) || (mo > 12);
      leap = (y != int'(BadBcd)) && (y % 4 == 0);
      lim  = fl[FlagMonth] ? 31 : month_days(mo, leap);
      fl[FlagDay]    = (d == int'(BadBcd)) || (d == 0) || (d > lim);
      fl[FlagHour]   = (h > 23);
      fl[FlagMinute] = (mi > 59);
      fl[FlagSecond] = (s > 59);
      // Any problem falls back to the epoch
      if (fl != '0) begin
        y = 0; mo = 1; d = 1; h = 0; mi = 0; s = 0; leap = 1'b1;
        flagged++;
      end
      cnt = 365 * y + (y + 3) / 4 + d + ((mo > 2 && leap) ? 1 : 0);
      for (int m = 1; m < mo; m++) cnt += month_days(m, 1'b0);
      // Borrow down from seconds into days
      sl = s - int'(ofs.seconds);
      ml = mi - int'(ofs.minutes);
      hl = h - int'(ofs.hours);
      borrow = 1'b0;
      if (sl < 0) begin
        sl += 60; ml -= 1;
      end
      if (ml < 0) begin
        ml += 60; hl -= 1;
      end
      if (hl < 0) begin
        hl += 24; borrow = 1'b1;
      end
      res.error_flags   = fl;
      res.day_count     = 16'(cnt);
      res.local_days    = 16'(cnt) - ofs.days - 16'(borrow);
      res.local_hours   = 5'(hl);
      res.local_minutes = 6'(ml);
      res.local_seconds = 6'(sl);
      return res;
    endfunction

    function void note_reading(input rtc_in_t r);
      readings++;
      pending_results.push_back(evaluate_reading(r));
    endfunction

    function void report(input string field, input int unsigned want, input int unsigned got);
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
      errors++;
    endfunction

    // Compare a result beat against the oldest prediction
    function void check_result(input rtc_out_t got);
      rtc_out_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing outstanding, expected none actual %p",
                 $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.error_flags !== want.error_flags)
        report("error_flags", want.error_flags, got.error_flags);
      if (got.day_count !== want.day_count)
        report("day_count", want.day_count, got.day_count);
      if (got.local_days !== want.local_days)
        report("local_days", 16'(want.local_days), 16'(got.local_days));
      if (got.local_hours !== want.local_hours)
        report("local_hours", want.local_hours, got.local_hours);
      if (got.local_minutes !== want.local_minutes)
        report("local_minutes", want.local_minutes, got.local_minutes);
      if (got.local_seconds !== want.local_seconds)
        report("local_seconds", want.local_seconds, got.local_seconds);
    endfunction
  endclass

  rtc_reading_scoreboard sb;

  // Sample handshakes at the edge: results, register writes, accepted readings
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) sb.check_result(result_o);
      if (cfg_we_i) sb.write_offset_reg(cfg_idx_i, cfg_wdata_i);
      if (start_i && !busy_o) sb.note_reading(item_i);
    end
  end

  // Hold start and the reading until a beat is taken; start stays high on return
  task automatic drive_reading(input rtc_in_t r);
    start_i <= 1'b1;
    item_i  <= r;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic send_raw(input bit pl, input bit h24, input logic [7:0] y, input logic [7:0] mo,
                          input logic [7:0] d, input logic [7:0] h, input logic [7:0] mi,
                          input logic [7:0] s);
    rtc_in_t r;
    r = '{status_power_lost: pl, status_24hour: h24, year_bcd: y, month_bcd: mo,
          day_bcd: d, hour_bcd: h, minute_bcd: mi, second_bcd: s};
    drive_reading(r);
  endtask

  task automatic idle_sender();
    start_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  // Drop start, wait out every outstanding beat, then let the unit settle
  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Program the full offset; a stray index goes first and must be ignored
  task automatic program_offset(input logic [15:0] days, input logic [15:0] hrs,
                                input logic [15:0] mins, input logic [15:0] secs);
    cfg_write(CfgIdxW'($urandom_range(4, 255)), CfgDataW'($urandom));
    cfg_write(RegOffsetDays, days);
    cfg_write(RegOffsetHours, hrs);
    cfg_write(RegOffsetMinutes, mins);
    cfg_write(RegOffsetSeconds, secs);
    cfg_we_i <= 1'b0;
  endtask

  // Field extremes, calendar corners and every error flag
  task automatic run_directed();
    send_raw(0, 1, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00);
    send_raw(0, 1, 8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59);
    send_raw(0, 1, 8'h00, 8'h02, 8'h29, 8'h12, 8'h30, 8'h30);
    send_raw(0, 1, 8'h24, 8'h02, 8'h29, 8'h00, 8'h00, 8'h01);
    send_raw(0, 1, 8'h23, 8'h02, 8'h29, 8'h06, 8'h07, 8'h08);
    send_raw(0, 1, 8'h23, 8'h02, 8'h28, 8'h06, 8'h07, 8'h08);
    send_raw(0, 1, 8'h24, 8'h02, 8'h30, 8'h06, 8'h07, 8'h08);
    send_raw(0, 1, 8'h50, 8'h04, 8'h31, 8'h11, 8'h22, 8'h33);
    send_raw(0, 1, 8'h50, 8'h04, 8'h30, 8'h11, 8'h22, 8'h33);
    send_raw(0, 1, 8'h10, 8'h01, 8'h32, 8'h01, 8'h02, 8'h03);
    send_raw(0, 1, 8'h10, 8'h01, 8'h00, 8'h01, 8'h02, 8'h03);
    send_raw(0, 1, 8'h10, 8'h00, 8'h31, 8'h01, 8'h02, 8'h03);
    send_raw(0, 1, 8'h10, 8'h13, 8'h32, 8'h01, 8'h02, 8'h03);
    send_raw(0, 1, 8'h10, 8'h1A, 8'h05, 8'h01, 8'h02, 8'h03);
    send_raw(0, 1, 8'hA0, 8'h03, 8'h15, 8'h01, 8'h02, 8'h03);
    send_raw(0, 1, 8'h9A, 8'h03, 8'h15, 8'h01, 8'h02, 8'h03);
    send_raw(0, 1, 8'h05, 8'h06, 8'h15, 8'h24, 8'h00, 8'h00);
    send_raw(0, 1, 8'h05, 8'h06, 8'h15, 8'h9F, 8'h60, 8'h00);
    send_raw(0, 1, 8'h05, 8'h06, 8'h15, 8'h23, 8'h59, 8'h60);
    send_raw(0, 1, 8'h05, 8'h06, 8'h15, 8'h00, 8'h00, 8'h5A);
    send_raw(1, 1, 8'h42, 8'h07, 8'h04, 8'h10, 8'h20, 8'h30);
    send_raw(0, 0, 8'h42, 8'h07, 8'h04, 8'h10, 8'h20, 8'h30);
    send_raw(1, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // Mostly well-formed dates with random content; now and then one field, or the whole reading, is broken
  function automatic rtc_in_t random_reading();
    rtc_in_t     r;
    logic [63:0] raw;
    int          y, mo, dim;
    y   = $urandom_range(0, 99);
    mo  = $urandom_range(1, 12);
    dim = month_days(mo, (y % 4) == 0);
    r.status_power_lost = ($urandom_range(0, 19) == 0);
    r.status_24hour     = ($urandom_range(0, 19) != 0);
    r.year_bcd   = to_bcd(y);
    r.month_bcd  = to_bcd(mo);
    r.day_bcd    = to_bcd(($urandom_range(0, 3) == 0) ? dim : $urandom_range(1, dim));
    r.hour_bcd   = to_bcd($urandom_range(0, 23));
    r.minute_bcd = to_bcd($urandom_range(0, 59));
    r.second_bcd = to_bcd($urandom_range(0, 59));
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 11))
        0:  r.year_bcd   = 8'($urandom);
        1:  r.month_bcd  = 8'($urandom);
        2:  r.day_bcd    = 8'($urandom);
        3:  r.hour_bcd   = 8'($urandom);
        4:  r.minute_bcd = 8'($urandom);
        5:  r.second_bcd = 8'($urandom);
        6:  r.day_bcd    = to_bcd(dim + 1);
        7:  r.month_bcd  = $urandom_range(0, 1) ? 8'h00 : 8'h13;
        8:  r.hour_bcd   = 8'h24;
        9:  r.minute_bcd = 8'h60;
        10: r.second_bcd = 8'h60;
        default: begin
          raw = {$urandom, $urandom};
          r   = raw[$bits(rtc_in_t)-1:0];
        end
      endcase
    end
    return r;
  endfunction

  initial begin
    bit gappy;
    sb          = new();
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      // Offset extremes first, including masked and clamped write data, then random
      case (ph)
        0: ;
        1: program_offset(16'h7FFF, 16'hFFFF, 16'd59, 16'h003F);
        2: program_offset(16'h8000, 16'hFFE0, 16'hFFC0, 16'h0000);
        3: program_offset(16'hFFFF, 16'd1, 16'd1, 16'd1);
        default: program_offset(16'($urandom),
                                $urandom_range(0, 1) ? 16'($urandom_range(0, 23)) : 16'($urandom),
                                $urandom_range(0, 1) ? 16'($urandom_range(0, 59)) : 16'($urandom),
                                $urandom_range(0, 1) ? 16'($urandom_range(0, 59)) : 16'($urandom));
      endcase
      gappy = (ph != NumPhases - 1) && (ph % 3 != 2);
      if (ph <= 2) run_directed();
      repeat (ItemsPerPhase) begin
        drive_reading(random_reading());
        if (gappy && $urandom_range(0, 3) == 0) idle_sender();
      end
      drain();
    end

    if (sb.pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending_results.size());
      sb.errors++;
    end
    $display("Checked %0d readings (%0d flagged) over %0d offset settings, %0d register writes.",
             sb.readings, sb.flagged, NumPhases, sb.reg_writes);
    if (sb.errors == 0) begin
      $display("bcd_rtc_reading_validate_and_day_count_unit_tb: done, clean");
    end else begin
      $display("bcd_rtc_reading_validate_and_day_count_unit_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("Timeout with %0d results outstanding", sb.pending_results.size());
    $display("bcd_rtc_reading_validate_and_day_count_unit_tb: done, errors");
    $finish;
  end

endmodule
